// File: rtl/der_rsa_private_key_parser_core_macros.svh
// Assertion macros shared by the RTL of the DER RSA key parser.
`ifndef DER_RSA_PRIVATE_KEY_PARSER_CORE_MACROS_SVH
`define DER_RSA_PRIVATE_KEY_PARSER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DRPP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DRPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/drpp_pkg.sv
// Types, codes and constants of the DER RSA private key parser.
package drpp_pkg;

    // Field widths of the input and result words.
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FIELD_W  = 4;
    localparam int POS_W    = 9;
    localparam int ERR_W    = 3;
    localparam int ACC_W    = 32;

    // DER constants.
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;

    // Number of INTEGERs in an RSAPrivateKey.
    localparam int NUM_FIELDS = 9;

    // Parameter defaults.
    localparam int DEF_MAX_INT_BYTES = 512;
    localparam int DEF_MAX_LEN_BYTES = 4;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_SEQ_TAG,
        PH_SEQ_LEN,
        PH_SEQ_LEN_EXT,
        PH_INT_TAG,
        PH_INT_LEN,
        PH_INT_LEN_EXT,
        PH_CONTENT,
        PH_TRAIL,
        PH_ERR
    } t_phase;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_HEADER,
        ST_CONTENT,
        ST_DONE,
        ST_ERROR,
        ST_IGNORED
    } t_status;

    // Error codes.
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE,
        ERR_SEQ_TAG,
        ERR_LEN_LONG,
        ERR_SEQ_MISMATCH,
        ERR_INT_TAG,
        ERR_TRUNCATED,
        ERR_TOO_BIG
    } t_err;

    // One result word.
    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] field_index;
        logic [POS_W-1:0]   byte_position;
        logic [DATA_W-1:0]  value_byte;
        logic               field_last;
        t_err               error_code;
    } t_result;

endpackage

// File: rtl/drpp_in_if.sv
// Input channel of the DER RSA key parser: one buffer byte per word.
interface drpp_in_if;
    import drpp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// File: rtl/drpp_out_if.sv
// Result channel of the DER RSA key parser: one result word per input byte.
interface drpp_out_if;
    import drpp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  field_index;
    logic [POS_W-1:0]    byte_position;
    logic [DATA_W-1:0]   value_byte;
    logic                field_last;
    logic [ERR_W-1:0]    error_code;

    modport source (output valid, output status, output field_index, output byte_position,
                    output value_byte, output field_last, output error_code, input ready);
    modport sink   (input valid, input status, input field_index, input byte_position,
                    input value_byte, input field_last, input error_code, output ready);
endinterface

// File: rtl/der_rsa_private_key_parser_core.sv
// Streaming DER parser for a PKCS#1 RSAPrivateKey, one byte per word.
//
// i_in carries the key buffer one byte per word, with end_of_buffer set on the
// final byte. o_res returns exactly one result word per input word: header
// bytes, content bytes tagged with field index and little-endian position,
// ignored bytes, and on the final byte a done or error status.
// The first error is held until the final byte, where it is reported; the
// parser then re-arms for the next buffer on its own.
// A result word is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the receiver keeps up; the phase update
// is combinational and sits between the accepted byte and the result register.
// If the receiver stalls, the result register holds its word and i_in.ready
// drops until that word is taken; a new byte is taken in the same cycle in
// which the waiting word leaves.
// Reset (i_rst_n low at a clock edge) returns the parser to expect a SEQUENCE
// tag and empties the result register.
// MAX_INT_BYTES bounds the accepted INTEGER length; MAX_LEN_BYTES bounds the
// number of long-form length bytes.
module der_rsa_private_key_parser_core #(
    parameter int MAX_INT_BYTES = drpp_pkg::DEF_MAX_INT_BYTES,
    parameter int MAX_LEN_BYTES = drpp_pkg::DEF_MAX_LEN_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    drpp_in_if.sink    i_in,
    drpp_out_if.source o_res
);
    import drpp_pkg::*;

    `include "der_rsa_private_key_parser_core_macros.svh"

    localparam int CW = $clog2(MAX_INT_BYTES + 1);
    localparam int LW = $clog2(MAX_LEN_BYTES + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    // Parser state.
    t_phase             r_phase,     n_phase;
    logic [ACC_W-1:0]   r_seq_rem,   n_seq_rem;
    logic [ACC_W-1:0]   r_acc,       n_acc;
    logic [LW-1:0]      r_left,      n_left;
    logic [FIELD_W-1:0] r_field,     n_field;
    logic [CW-1:0]      r_content,   n_content;
    t_err               r_err,       n_err;
    logic               r_done,      n_done;

    // Result register.
    t_result r_out, n_out;
    logic    r_out_valid;

    logic w_in_ready;
    logic w_accept;

    assign w_in_ready = !r_out_valid || o_res.ready;
    assign w_accept   = i_in.valid && w_in_ready;

    // Phase update and result word for the byte at the input.
    always_comb begin
        logic [DATA_W-1:0]  b;
        logic [ACC_W-1:0]   acc_next;
        logic [LW-1:0]      left_next;
        logic [ACC_W-1:0]   len_val;
        logic [FIELD_W-1:0] field_next;
        logic [PW-1:0]      pos_w;
        logic               fin_seq;
        logic               fin_int;
        logic               fld_done;
        logic               do_fail;
        t_err               fail_code;
        t_err               ec;

        b          = i_in.data_byte;
        n_phase    = r_phase;
        n_seq_rem  = r_seq_rem;
        n_acc      = r_acc;
        n_left     = r_left;
        n_field    = r_field;
        n_content  = r_content;
        n_err      = r_err;
        n_done     = r_done;
        fin_seq    = 1'b0;
        fin_int    = 1'b0;
        fld_done   = 1'b0;
        do_fail    = 1'b0;
        fail_code  = ERR_NONE;
        len_val    = '0;
        ec         = ERR_NONE;
        n_out      = '0;
        n_out.status     = ST_IGNORED;
        n_out.error_code = ERR_NONE;

        // Next step of a long-form length: saturate once it would exceed 32 bits.
        acc_next   = (r_acc[ACC_W-1:ACC_W-8] != 8'h00) ? '1 : {r_acc[ACC_W-9:0], b};
        left_next  = (r_left != '0) ? r_left - 1'b1 : r_left;
        field_next = r_field + 1'b1;
        pos_w      = PW'(r_content) - 1'b1;

        unique case (r_phase)
            PH_SEQ_TAG: begin
                n_out.status = ST_HEADER;
                if (b != TAG_SEQUENCE) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_SEQ_TAG;
                end else begin
                    n_phase = PH_SEQ_LEN;
                end
            end
            PH_SEQ_LEN, PH_INT_LEN, PH_SEQ_LEN_EXT, PH_INT_LEN_EXT, PH_INT_TAG,
            PH_CONTENT, PH_TRAIL: begin
                if (r_phase == PH_SEQ_LEN || r_phase == PH_SEQ_LEN_EXT) begin
                    n_out.status = ST_HEADER;
                end else if (r_seq_rem == '0) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_SEQ_MISMATCH;
                end else begin
                    n_seq_rem         = r_seq_rem - 1'b1;
                    n_out.field_index = r_field;
                    n_out.status      = ST_HEADER;
                end

                if (!do_fail) begin
                    // First length byte, short or long form.
                    if (r_phase == PH_SEQ_LEN || r_phase == PH_INT_LEN) begin
                        if (!b[7]) begin
                            n_acc   = {{(ACC_W-7){1'b0}}, b[6:0]};
                            len_val = n_acc;
                            fin_seq = (r_phase == PH_SEQ_LEN);
                            fin_int = (r_phase == PH_INT_LEN);
                        end else if ({25'b0, b[6:0]} > 32'(MAX_LEN_BYTES)) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_LEN_LONG;
                        end else begin
                            n_acc  = '0;
                            n_left = LW'(b[6:0]);
                            if (b[6:0] == 7'd0) begin
                                len_val = '0;
                                fin_seq = (r_phase == PH_SEQ_LEN);
                                fin_int = (r_phase == PH_INT_LEN);
                            end else if (r_phase == PH_SEQ_LEN) begin
                                n_phase = PH_SEQ_LEN_EXT;
                            end else begin
                                n_phase = PH_INT_LEN_EXT;
                            end
                        end
                    end

                    // Further long-form length bytes.
                    if (r_phase == PH_SEQ_LEN_EXT || r_phase == PH_INT_LEN_EXT) begin
                        n_acc  = acc_next;
                        n_left = left_next;
                        if (left_next == '0) begin
                            len_val = acc_next;
                            fin_seq = (r_phase == PH_SEQ_LEN_EXT);
                            fin_int = (r_phase == PH_INT_LEN_EXT);
                        end
                    end

                    // INTEGER tag.
                    if (r_phase == PH_INT_TAG) begin
                        if (b != TAG_INTEGER) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_INT_TAG;
                        end else begin
                            n_phase = PH_INT_LEN;
                        end
                    end

                    // Content byte, counted down to position zero.
                    if (r_phase == PH_CONTENT) begin
                        n_out.status        = ST_CONTENT;
                        n_out.byte_position = pos_w[POS_W-1:0];
                        n_out.value_byte    = b;
                        n_content           = r_content - 1'b1;
                        if (r_content == CW'(1)) begin
                            n_out.field_last = 1'b1;
                            fld_done         = 1'b1;
                        end
                    end

                    // Bytes after the last INTEGER but inside the SEQUENCE.
                    if (r_phase == PH_TRAIL) begin
                        n_out.status      = ST_IGNORED;
                        n_out.field_index = '0;
                    end
                end
            end
            PH_ERR: begin
                n_phase = PH_ERR;
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase

        // SEQUENCE length complete.
        if (fin_seq) begin
            n_seq_rem = len_val;
            n_field   = '0;
            n_phase   = PH_INT_TAG;
        end

        // INTEGER length complete.
        if (fin_int) begin
            if (len_val > 32'(MAX_INT_BYTES)) begin
                do_fail   = 1'b1;
                fail_code = ERR_TOO_BIG;
            end else begin
                n_content = CW'(len_val);
                if (len_val == '0) begin
                    fld_done = 1'b1;
                end else begin
                    n_phase = PH_CONTENT;
                end
            end
        end

        // Move on to the next INTEGER or to the trailing bytes.
        if (fld_done) begin
            n_field = field_next;
            if (field_next >= FIELD_W'(NUM_FIELDS)) begin
                n_done  = 1'b1;
                n_phase = PH_TRAIL;
            end else begin
                n_phase = PH_INT_TAG;
            end
        end

        // Hold the first error.
        if (do_fail) begin
            n_phase = PH_ERR;
            if (r_err == ERR_NONE) begin
                n_err = fail_code;
            end
        end

        // Once in error every byte is ignored.
        if (n_phase == PH_ERR) begin
            n_out        = '0;
            n_out.status = ST_IGNORED;
        end

        // Final byte: report the outcome and re-arm.
        if (i_in.end_of_buffer) begin
            if (n_err != ERR_NONE) begin
                ec = n_err;
            end else if (n_phase == PH_SEQ_TAG || n_phase == PH_SEQ_LEN ||
                         n_phase == PH_SEQ_LEN_EXT) begin
                ec = ERR_TRUNCATED;
            end else if (n_seq_rem != '0) begin
                ec = ERR_SEQ_MISMATCH;
            end else if (!n_done) begin
                ec = ERR_TRUNCATED;
            end
            if (ec != ERR_NONE) begin
                n_out            = '0;
                n_out.status     = ST_ERROR;
                n_out.error_code = ec;
            end else begin
                n_out.status = ST_DONE;
            end
            n_phase   = PH_SEQ_TAG;
            n_seq_rem = '0;
            n_acc     = '0;
            n_left    = '0;
            n_field   = '0;
            n_content = '0;
            n_err     = ERR_NONE;
            n_done    = 1'b0;
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEQ_TAG;
            r_seq_rem <= '0;
            r_acc     <= '0;
            r_left    <= '0;
            r_field   <= '0;
            r_content <= '0;
            r_err     <= ERR_NONE;
            r_done    <= 1'b0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_seq_rem <= n_seq_rem;
            r_acc     <= n_acc;
            r_left    <= n_left;
            r_field   <= n_field;
            r_content <= n_content;
            r_err     <= n_err;
            r_done    <= n_done;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    // Port drive.
    assign i_in.ready          = w_in_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out.status;
    assign o_res.field_index   = r_out.field_index;
    assign o_res.byte_position = r_out.byte_position;
    assign o_res.value_byte    = r_out.value_byte;
    assign o_res.field_last    = r_out.field_last;
    assign o_res.error_code    = r_out.error_code;

    // Checks on the parser state and the result word.
    `DRPP_ASSERT_SAME(a_content_nonzero, r_phase == PH_CONTENT, r_content != '0, "content phase with no bytes left")
    `DRPP_ASSERT_SAME(a_err_latched, r_phase == PH_ERR, r_err != ERR_NONE, "error phase without a held error")
    `DRPP_ASSERT_NEXT(a_rearm, w_accept && i_in.end_of_buffer, r_phase == PH_SEQ_TAG && r_err == ERR_NONE && !r_done, "parser did not re-arm after the final byte")
    `DRPP_ASSERT_SAME(a_code_status, r_out_valid, (r_out.status == ST_ERROR) == (r_out.error_code != ERR_NONE), "error code does not match status")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the streaming DER RSA private key parser core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import drpp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Outcome of feeding one byte to the length decoder.
    typedef enum {
        LS_FAIL,
        LS_DONE,
        LS_MORE
    } t_len_step;

    logic i_clk;
    logic i_rst_n;

    drpp_in_if  in_if ();
    drpp_out_if res_if ();

    der_rsa_private_key_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    // Parser state as the predictor tracks it.
    t_phase      prs_phase;
    logic [31:0] seq_left;
    logic [31:0] len_acc;
    logic [2:0]  len_bytes_left;
    logic [3:0]  field_cnt;
    logic [31:0] content_left;
    t_err        err_latched;
    logic        fields_done;

    t_result     pending_words[$];
    logic [7:0]  der_buf[$];
    logic [7:0]  len_code[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycle_count = 0;

    // Predictor: parser state handling.
    function automatic void clear_parser();
        prs_phase      = PH_SEQ_TAG;
        seq_left       = '0;
        len_acc        = '0;
        len_bytes_left = '0;
        field_cnt      = '0;
        content_left   = '0;
        err_latched    = ERR_NONE;
        fields_done    = 1'b0;
    endfunction

    function automatic void latch_err(t_err code);
        if (err_latched == ERR_NONE) begin
            err_latched = code;
        end
        prs_phase = PH_ERR;
    endfunction

    // First byte of a DER length: short form, or the count of long-form bytes.
    function automatic t_len_step len_first(logic [7:0] b);
        if (b < 8'h80) begin
            len_acc = 32'(b);
            return LS_DONE;
        end
        if (int'(b) - 128 > DEF_MAX_LEN_BYTES) begin
            latch_err(ERR_LEN_LONG);
            return LS_FAIL;
        end
        len_acc = '0;
        len_bytes_left = 3'(b - 8'h80);
        return (len_bytes_left == 0) ? LS_DONE : LS_MORE;
    endfunction

    // Next big-endian length byte; the value saturates rather than wrapping.
    function automatic bit len_next(logic [7:0] b);
        if (len_acc[31:24] != 0) begin
            len_acc = '1;
        end else begin
            len_acc = {len_acc[23:0], b};
        end
        if (len_bytes_left != 0) begin
            len_bytes_left = len_bytes_left - 1;
        end
        return len_bytes_left == 0;
    endfunction

    function automatic void field_finished();
        field_cnt = field_cnt + 1;
        if (field_cnt >= NUM_FIELDS) begin
            fields_done = 1'b1;
            prs_phase = PH_TRAIL;
        end else begin
            prs_phase = PH_INT_TAG;
        end
    endfunction

    function automatic void close_seq_len();
        seq_left  = len_acc;
        field_cnt = '0;
        prs_phase = PH_INT_TAG;
    endfunction

    function automatic void close_int_len();
        if (len_acc > DEF_MAX_INT_BYTES) begin
            latch_err(ERR_TOO_BIG);
            return;
        end
        content_left = len_acc;
        if (content_left == 0) begin
            field_finished();
        end else begin
            prs_phase = PH_CONTENT;
        end
    endfunction

    // Works out the result word for one accepted byte and advances the state.
    function automatic t_result parse_byte(logic [7:0] b, logic last);
        t_result   r;
        t_err      ec;
        t_len_step ls;
        r = '0;
        r.status = ST_IGNORED;
        r.error_code = ERR_NONE;
        case (prs_phase)
            PH_SEQ_TAG: begin
                r.status = ST_HEADER;
                if (b != TAG_SEQUENCE) begin
                    latch_err(ERR_SEQ_TAG);
                end else begin
                    prs_phase = PH_SEQ_LEN;
                end
            end
            PH_SEQ_LEN: begin
                r.status = ST_HEADER;
                ls = len_first(b);
                if (ls == LS_DONE) begin
                    close_seq_len();
                end else if (ls == LS_MORE) begin
                    prs_phase = PH_SEQ_LEN_EXT;
                end
            end
            PH_SEQ_LEN_EXT: begin
                r.status = ST_HEADER;
                if (len_next(b)) begin
                    close_seq_len();
                end
            end
            PH_INT_TAG, PH_INT_LEN, PH_INT_LEN_EXT, PH_CONTENT, PH_TRAIL: begin
                if (seq_left == 0) begin
                    // A byte beyond the declared sequence length.
                    latch_err(ERR_SEQ_MISMATCH);
                end else begin
                    seq_left = seq_left - 1;
                    r.field_index = field_cnt;
                    if (prs_phase == PH_INT_TAG) begin
                        r.status = ST_HEADER;
                        if (b != TAG_INTEGER) begin
                            latch_err(ERR_INT_TAG);
                        end else begin
                            prs_phase = PH_INT_LEN;
                        end
                    end else if (prs_phase == PH_INT_LEN) begin
                        r.status = ST_HEADER;
                        ls = len_first(b);
                        if (ls == LS_DONE) begin
                            close_int_len();
                        end else if (ls == LS_MORE) begin
                            prs_phase = PH_INT_LEN_EXT;
                        end
                    end else if (prs_phase == PH_INT_LEN_EXT) begin
                        r.status = ST_HEADER;
                        if (len_next(b)) begin
                            close_int_len();
                        end
                    end else if (prs_phase == PH_CONTENT) begin
                        r.status = ST_CONTENT;
                        r.byte_position = 9'(content_left - 1);
                        r.value_byte = b;
                        content_left = content_left - 1;
                        if (content_left == 0) begin
                            r.field_last = 1'b1;
                            field_finished();
                        end
                    end else begin
                        r.status = ST_IGNORED;
                        r.field_index = '0;
                    end
                end
            end
            default: begin
                prs_phase = PH_ERR;
            end
        endcase

        // Once an error is latched the byte carries nothing.
        if (prs_phase == PH_ERR) begin
            r = '0;
            r.status = ST_IGNORED;
            r.error_code = ERR_NONE;
        end

        // The final byte reports the verdict on the whole buffer.
        if (last) begin
            if (err_latched != ERR_NONE) begin
                ec = err_latched;
            end else if (prs_phase <= PH_SEQ_LEN_EXT) begin
                ec = ERR_TRUNCATED;
            end else if (seq_left != 0) begin
                ec = ERR_SEQ_MISMATCH;
            end else if (!fields_done) begin
                ec = ERR_TRUNCATED;
            end else begin
                ec = ERR_NONE;
            end
            if (ec != ERR_NONE) begin
                r = '0;
                r.status = ST_ERROR;
                r.error_code = ec;
            end else begin
                r.status = ST_DONE;
            end
            clear_parser();
        end
        return r;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: every accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.status        = t_status'(res_if.status);
            got.field_index   = res_if.field_index;
            got.byte_position = res_if.byte_position;
            got.value_byte    = res_if.value_byte;
            got.field_last    = res_if.field_last;
            got.error_code    = t_err'(res_if.error_code);
            if (pending_words.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result word st=%0d fi=%0d pos=%0d val=%02h last=%0d err=%0d",
                         $time, got.status, got.field_index, got.byte_position,
                         got.value_byte, got.field_last, got.error_code);
            end else begin
                want = pending_words.pop_front();
                if (got.status !== want.status || got.field_index !== want.field_index ||
                    got.byte_position !== want.byte_position ||
                    got.value_byte !== want.value_byte ||
                    got.field_last !== want.field_last ||
                    got.error_code !== want.error_code) begin
                    mismatch_count++;
                    $display("%0t: mismatch expected st=%0d fi=%0d pos=%0d val=%02h last=%0d err=%0d",
                             $time, want.status, want.field_index, want.byte_position,
                             want.value_byte, want.field_last, want.error_code);
                    $display("%0t:          actual   st=%0d fi=%0d pos=%0d val=%02h last=%0d err=%0d",
                             $time, got.status, got.field_index, got.byte_position,
                             got.value_byte, got.field_last, got.error_code);
                end
            end
        end
    end

    // Sends one byte, with random idle cycles ahead of it.
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.data_byte     <= b;
        in_if.end_of_buffer <= last;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        pending_words.push_back(parse_byte(b, last));
    endtask

    task automatic send_buffer();
        foreach (der_buf[i]) begin
            send_byte(der_buf[i], i == der_buf.size() - 1);
        end
    endtask

    // Holds the sender until every expected word has come back.
    task automatic wait_results_done();
        in_if.valid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    // DER length encoding; lengths below 128 take the short or long form at random.
    function automatic void encode_len(int unsigned n);
        int need;
        int k;
        len_code = {};
        need = (n == 0) ? 0 : (n < 256) ? 1 : (n < 65536) ? 2 : (n < 32'h0100_0000) ? 3 : 4;
        if (n < 128 && $urandom_range(2) != 0) begin
            len_code.push_back(8'(n));
        end else begin
            k = $urandom_range(DEF_MAX_LEN_BYTES, need);
            len_code.push_back(8'(8'h80 + k));
            for (int i = k - 1; i >= 0; i--) begin
                len_code.push_back(8'(n >> (8 * i)));
            end
        end
    endfunction

    // Builds a key buffer with random content; seq_delta skews the declared length.
    task automatic build_key(input int unsigned lens[NUM_FIELDS], input int trail,
                             input int seq_delta);
        logic [7:0] body[$];
        body = {};
        for (int f = 0; f < NUM_FIELDS; f++) begin
            body.push_back(TAG_INTEGER);
            encode_len(lens[f]);
            body = {body, len_code};
            if (lens[f] > DEF_MAX_INT_BYTES) begin
                break;
            end
            repeat (lens[f]) body.push_back(8'($urandom_range(255)));
        end
        repeat (trail) body.push_back(8'($urandom_range(255)));
        encode_len(body.size() + seq_delta);
        der_buf = {TAG_SEQUENCE, len_code, body};
    endtask

    // Sequence header cases: bad tag, short buffers, long length fields, excess bytes.
    task automatic test_sequence_header();
        der_buf = {8'h31};
        send_buffer();
        der_buf = {TAG_SEQUENCE};
        send_buffer();
        der_buf = {TAG_SEQUENCE, 8'h85, 8'hFF};
        send_buffer();
        der_buf = {TAG_SEQUENCE, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, TAG_INTEGER};
        send_buffer();
        der_buf = {TAG_SEQUENCE, 8'h80};
        send_buffer();
        der_buf = {TAG_SEQUENCE, 8'h00, 8'hAB};
        send_buffer();
    endtask

    // Integer cases: empty integers, the largest integer, trailing bytes and faults.
    task automatic test_integer_fields();
        build_key('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, 0);
        send_buffer();
        build_key('{1, 512, 1, 0, 1, 2, 3, 2, 1}, 0, 0);
        send_buffer();
        build_key('{1, 3, 1, 1, 1, 1, 1, 1, 1}, 2, 0);
        send_buffer();
        der_buf = {TAG_SEQUENCE, 8'h03, 8'h04, 8'h01, 8'h00};
        send_buffer();
        der_buf = {TAG_SEQUENCE, 8'h04, TAG_INTEGER, 8'h82, 8'h02, 8'h01};
        send_buffer();
        der_buf = {TAG_SEQUENCE, 8'h03, TAG_INTEGER, 8'h88, 8'h00};
        send_buffer();
        build_key('{2, 4, 1, 1, 1, 1, 1, 1, 1}, 0, 0);
        der_buf = der_buf[0:8];
        send_buffer();
        build_key('{1, 1, 1, 1, 1, 1, 1, 1, 2}, 0, 1);
        send_buffer();
        build_key('{1, 1, 1, 1, 1, 1, 1, 1, 2}, 0, -1);
        send_buffer();
    endtask

    // Random keys, mostly well formed, with some broken ones and plain noise.
    task automatic test_random_keys(int s_pct, int r_pct, int n_bytes);
        int unsigned lens[NUM_FIELDS];
        int sent;
        int pick;
        int trail;
        int delta;
        int idx;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                der_buf = {};
                if ($urandom_range(1) != 0) begin
                    der_buf.push_back(TAG_SEQUENCE);
                end
                repeat ($urandom_range(6, 1)) der_buf.push_back(8'($urandom_range(255)));
            end else begin
                foreach (lens[f]) begin
                    idx = $urandom_range(99);
                    if (pick < 11 && f == 1) begin
                        lens[f] = ($urandom_range(1) != 0) ? 512 : $urandom_range(512, 129);
                    end else if (idx < 2) begin
                        lens[f] = $urandom_range(700, 513);
                    end else if (idx < 10) begin
                        lens[f] = $urandom_range(140, 7);
                    end else begin
                        lens[f] = $urandom_range(6, 0);
                    end
                end
                trail = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0;
                pick = $urandom_range(99);
                delta = (pick < 6) ? (($urandom_range(1) != 0) ? 1 : -1) : 0;
                build_key(lens, trail, delta);
                if (pick >= 6 && pick < 12) begin
                    idx = $urandom_range(der_buf.size() - 1);
                    der_buf[idx] = 8'($urandom_range(255));
                end else if (pick >= 12 && pick < 18) begin
                    idx = $urandom_range(der_buf.size() - 1, 1);
                    der_buf = der_buf[0:idx-1];
                end else if (pick >= 18 && pick < 22) begin
                    repeat ($urandom_range(3, 1)) der_buf.push_back(8'($urandom_range(255)));
                end
            end
            send_buffer();
            sent += der_buf.size();
        end
        wait_results_done();
    endtask

    // Test sequence.
    initial begin
        clear_parser();
        in_if.valid         <= 1'b0;
        in_if.data_byte     <= '0;
        in_if.end_of_buffer <= 1'b0;
        i_rst_n             <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 17;
        recv_idle_pct = 77;
        test_sequence_header();
        test_integer_fields();
        wait_results_done();

        test_random_keys(17, 77, 100);
        test_random_keys(77, 17, 100);
        test_random_keys(0, 0, 100);

        wait_results_done();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
